// ----- hw/rtl/qed_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadrature decoder package
// Shared widths, command and register codes, and the item and configuration
// types of the quadrature decoder with button counter.
// ----------------------------------------------------------------------------
package qed_pkg;

	localparam int CMD_W      = 3;
	localparam int VALUE_W    = 16;
	localparam int THRESH_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int COUNTS_PER_DETENT_DEF = 4;
	localparam logic [THRESH_W-1:0] STEP_THRESHOLD_RST = 8'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENC   = 3'd0,
		CMD_BTN   = 3'd1,
		CMD_TURNS = 3'd2,
		CMD_STEP  = 3'd3,
		CMD_PRESS = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIR_INVERT   = 2'd0,
		REG_BUTTON_LEVEL = 2'd1,
		REG_STEP_THRESH  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             pin_a;
		logic             pin_b;
		logic             button_level;
	} item_t;

	typedef struct packed {
		logic                dir_invert;
		logic                button_active_level;
		logic [THRESH_W-1:0] step_threshold;
	} cfg_t;

endpackage

// ----- hw/rtl/quadrature_encoder_with_button_counter.sv -----
// ----------------------------------------------------------------------------
// Quadrature encoder decoder with button counter
// Counts x4 quadrature steps and button presses, and answers read commands.
//
//   Channel  Signals                                  Direction
//   input    in_valid in_ready cmd pin_a pin_b        in, ready out
//            button_level
//   output   out_valid out_ready read_value           out, ready in
//   config   cfg_valid cfg_ready cfg_index cfg_data   in, ready out
//
// One item is accepted per cycle while no read is held by a stalled result
// register; a read result is offered once it has moved from the input
// register into the result register.
// Reset clears the counters, the encoder and button history and the
// registers to their defaults. A stalled result register holds the item in
// the input register only when that item is a read; samples keep flowing.
// ----------------------------------------------------------------------------
module quadrature_encoder_with_button_counter #(
	parameter int COUNTS_PER_DETENT = qed_pkg::COUNTS_PER_DETENT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [qed_pkg::CMD_W-1:0]       cmd,
	input  logic                            pin_a,
	input  logic                            pin_b,
	input  logic                            button_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [qed_pkg::VALUE_W-1:0] read_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qed_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qed_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import qed_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	item_t              item_s1;
	logic               has_result;
	logic [VALUE_W-1:0] result;
	logic               out_free;
	logic               advance;
	logic [VALUE_W-1:0] read_bits;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign in_ready   = !valid_s1 || advance;
	assign read_value = $signed(read_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dir_invert          <= 1'b0;
			cfg_q.button_active_level <= 1'b0;
			cfg_q.step_threshold      <= STEP_THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIR_INVERT:   cfg_q.dir_invert          <= cfg_data[0];
				REG_BUTTON_LEVEL: cfg_q.button_active_level <= cfg_data[0];
				REG_STEP_THRESH:  cfg_q.step_threshold      <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, pin_a: pin_a, pin_b: pin_b, button_level: button_level};
		end
	end

	qed_core #(
		.COUNTS_PER_DETENT(COUNTS_PER_DETENT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.has_result(has_result),
		.result    (result)
	);

	qed_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.value     (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_value(read_bits)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && has_result && out_valid && !out_ready))
		else $error("Input stalled without a blocked read result.");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |=> out_valid)
		else $error("A read left the input stage without a result.");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("An accepted transfer was not captured.");

endmodule

// ----- hw/rtl/qed_core.sv -----
// ----------------------------------------------------------------------------
// Quadrature decoder core
// Holds the encoder and button state, applies one item per transfer and
// forms the read result from the current counters.
// ----------------------------------------------------------------------------
module qed_core #(
	parameter int COUNTS_PER_DETENT = qed_pkg::COUNTS_PER_DETENT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  qed_pkg::item_t               item,
	input  qed_pkg::cfg_t                cfg,
	output logic                         has_result,
	output logic [qed_pkg::VALUE_W-1:0]  result
);
	import qed_pkg::*;

	localparam int RECIP_SHIFT = VALUE_W + $clog2(COUNTS_PER_DETENT) + 1;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(COUNTS_PER_DETENT) - 64'd1) /
		64'(COUNTS_PER_DETENT));
	localparam logic signed [VALUE_W-1:0] COUNT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] COUNT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] PRESS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	function automatic logic [1:0] ring_pos(input logic [1:0] ab);
		ring_pos = {ab[1], ab[1] ^ ab[0]};
	endfunction

	logic [1:0]                 prev_ab_q;
	logic                       seen_q;
	logic signed [VALUE_W-1:0]  count_q;
	logic                       prev_btn_q;
	logic [VALUE_W-1:0]         press_q;

	logic [1:0]                 ab;
	logic [1:0]                 ring_delta;
	logic                       step_up;
	logic                       step_down;
	logic signed [VALUE_W-1:0]  count_inc;
	logic signed [VALUE_W-1:0]  count_dec;
	logic [VALUE_W-1:0]         mag;
	logic [PROD_W-1:0]          prod;
	logic [VALUE_W-1:0]         quo;
	logic [VALUE_W-1:0]         turns;
	logic                       step_fire;
	logic                       press_edge;

	always_comb begin
		ab         = {item.pin_a, item.pin_b};
		ring_delta = ring_pos(ab) - ring_pos(prev_ab_q);
		step_up    = cfg.dir_invert ? (ring_delta == 2'd3) : (ring_delta == 2'd1);
		step_down  = cfg.dir_invert ? (ring_delta == 2'd1) : (ring_delta == 2'd3);
		count_inc  = (count_q == COUNT_MAX) ? count_q : count_q + VALUE_W'(1);
		count_dec  = (count_q == COUNT_MIN) ? count_q : count_q - VALUE_W'(1);
		mag        = count_q[VALUE_W-1] ? (~count_q + VALUE_W'(1)) : count_q;
		prod       = PROD_W'(mag) * PROD_W'(RECIP);
		quo        = prod[RECIP_SHIFT +: VALUE_W];
		turns      = count_q[VALUE_W-1] ? (~quo + VALUE_W'(1)) : quo;
		step_fire  = count_q >= $signed({{(VALUE_W-THRESH_W){1'b0}}, cfg.step_threshold});
		press_edge = (item.button_level != prev_btn_q) &&
			(item.button_level == cfg.button_active_level);
	end

	always_comb begin
		has_result = 1'b0;
		result     = '0;
		unique case (item.cmd)
			CMD_TURNS: begin
				has_result = 1'b1;
				result     = turns;
			end
			CMD_STEP: begin
				has_result = 1'b1;
				result     = step_fire ? turns : '0;
			end
			CMD_PRESS: begin
				has_result = 1'b1;
				result     = press_q;
			end
			default: begin
				has_result = 1'b0;
				result     = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q  <= '0;
			seen_q     <= 1'b0;
			count_q    <= '0;
			prev_btn_q <= 1'b0;
			press_q    <= '0;
		end else if (fire) begin
			unique case (item.cmd)
				CMD_ENC: begin
					if (seen_q && step_up) begin
						count_q <= count_inc;
					end else if (seen_q && step_down) begin
						count_q <= count_dec;
					end
					prev_ab_q <= ab;
					seen_q    <= 1'b1;
				end
				CMD_BTN: begin
					if (press_edge && press_q != PRESS_MAX) begin
						press_q <= press_q + VALUE_W'(1);
					end
					prev_btn_q <= item.button_level;
				end
				CMD_TURNS: begin
					count_q <= '0;
				end
				CMD_STEP: begin
					if (step_fire) begin
						count_q <= '0;
					end
				end
				CMD_PRESS: begin
					press_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	a_press_fits: assert property (@(posedge clk) disable iff (!arst_n)
		!press_q[VALUE_W-1])
		else $error("Press count exceeded its saturation limit.");

	a_first_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.cmd == CMD_ENC && !seen_q) |=> $stable(count_q))
		else $error("The first encoder sample changed the count.");

	a_turns_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.cmd == CMD_TURNS) |=> (count_q == '0))
		else $error("A turns read did not clear the count.");

endmodule

// ----- hw/rtl/qed_out.sv -----
// ----------------------------------------------------------------------------
// Quadrature decoder result register
// Holds one read result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module qed_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [qed_pkg::VALUE_W-1:0]  value,
	output logic                         free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [qed_pkg::VALUE_W-1:0]  read_value
);
	import qed_pkg::*;

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;

	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign read_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value;
		end
	end

endmodule

// ----- verif/qed_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadrature decoder checker
// Watches the input, configuration and result channels of the quadrature
// decoder, keeps its own copy of the decoder state, predicts the value of
// every read command and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module qed_checker #(
	parameter int COUNTS_PER_DETENT = qed_pkg::COUNTS_PER_DETENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [qed_pkg::CMD_W-1:0]          cmd,
	input  logic                               pin_a,
	input  logic                               pin_b,
	input  logic                               button_level,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [qed_pkg::VALUE_W-1:0] read_value,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [qed_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qed_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 errors,
	output int                                 pending,
	output int                                 items_seen,
	output int                                 reads_checked,
	output int                                 writes_seen
);

	localparam int COUNT_MAX = 32767;
	localparam int COUNT_MIN = -32768;
	localparam int VALUE_W = qed_pkg::VALUE_W;

	logic [1:0]                         last_ab;
	logic                               ab_known;
	int                                 quarter;
	logic                               last_button;
	int                                 presses;
	logic                               dir_invert;
	logic                               active_level;
	logic [qed_pkg::THRESH_W-1:0]       threshold;
	logic signed [qed_pkg::VALUE_W-1:0] expected_reads[$];
	int                                 err_n;
	int                                 item_n;
	int                                 read_n;
	int                                 write_n;

	function automatic int ring_pos(input logic [1:0] ab);
		case (ab)
			2'b00: return 0;
			2'b01: return 1;
			2'b11: return 2;
			default: return 3;
		endcase
	endfunction

	function automatic int take_turns();
		int turns;
		turns = quarter / COUNTS_PER_DETENT;
		quarter = 0;
		return turns;
	endfunction

	task automatic predict_item(input logic [qed_pkg::CMD_W-1:0] c, input logic a,
		input logic b, input logic lvl);
		int                                 step;
		int                                 th;
		logic [1:0]                         ab;
		logic signed [qed_pkg::VALUE_W-1:0] value;
		ab = {a, b};
		th = int'(threshold);
		step = 0;
		case (c)
			qed_pkg::CMD_ENC: begin
				if (ab_known) begin
					case ((ring_pos(ab) - ring_pos(last_ab)) & 3)
						1: step = 1;
						3: step = -1;
						default: step = 0;
					endcase
					if (dir_invert)
						step = -step;
					quarter = quarter + step;
					if (quarter > COUNT_MAX)
						quarter = COUNT_MAX;
					if (quarter < COUNT_MIN)
						quarter = COUNT_MIN;
				end
				last_ab = ab;
				ab_known = 1'b1;
			end
			qed_pkg::CMD_BTN: begin
				if (lvl != last_button && lvl == active_level && presses < COUNT_MAX)
					presses++;
				last_button = lvl;
			end
			qed_pkg::CMD_TURNS: begin
				value = VALUE_W'(take_turns());
				expected_reads.push_back(value);
			end
			qed_pkg::CMD_STEP: begin
				if (quarter >= th)
					value = VALUE_W'(take_turns());
				else
					value = '0;
				expected_reads.push_back(value);
			end
			qed_pkg::CMD_PRESS: begin
				value = VALUE_W'(presses);
				presses = 0;
				expected_reads.push_back(value);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [qed_pkg::VALUE_W-1:0] exp_value;
		if (!arst_n) begin
			last_ab = 2'b00;
			ab_known = 1'b0;
			quarter = 0;
			last_button = 1'b0;
			presses = 0;
			dir_invert = 1'b0;
			active_level = 1'b0;
			threshold = qed_pkg::STEP_THRESHOLD_RST;
			expected_reads.delete();
			err_n = 0;
			item_n = 0;
			read_n = 0;
			write_n = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reads.size() == 0) begin
					err_n++;
					$display("%0t: result transfer with nothing expected, actual %0d",
						$time, read_value);
				end else begin
					exp_value = expected_reads.pop_front();
					read_n++;
					if (read_value !== exp_value) begin
						err_n++;
						$display("%0t: read_value mismatch, expected %0d, actual %0d",
							$time, exp_value, read_value);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				write_n++;
				case (cfg_index)
					qed_pkg::REG_DIR_INVERT: dir_invert = cfg_data[0];
					qed_pkg::REG_BUTTON_LEVEL: active_level = cfg_data[0];
					qed_pkg::REG_STEP_THRESH: threshold = cfg_data[qed_pkg::THRESH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				item_n++;
				predict_item(cmd, pin_a, pin_b, button_level);
			end
		end
		errors <= err_n;
		pending <= expected_reads.size();
		items_seen <= item_n;
		reads_checked <= read_n;
		writes_seen <= write_n;
	end

endmodule

// ----- verif/tb_quadrature_encoder_with_button_counter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadrature decoder testbench
// Drives the decoder with directed encoder, button and read items, then with
// random phases under several register settings and a long result stall.
// A checker beside the block predicts and compares every read.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_with_button_counter;

	import qed_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PHASES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [CMD_W-1:0]          cmd;
	logic                      pin_a;
	logic                      pin_b;
	logic                      button_level;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VALUE_W-1:0] read_value;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	int                        errors;
	int                        pending;
	int                        items_seen;
	int                        reads_checked;
	int                        writes_seen;

	logic                      hold_toggle = 1'b0;
	int                        ab_pos;
	int                        burst_left;
	logic                      btn_drive;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quadrature_encoder_with_button_counter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.pin_a        (pin_a),
		.pin_b        (pin_b),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	qed_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.pin_a         (pin_a),
		.pin_b         (pin_b),
		.button_level  (button_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_value    (read_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.items_seen    (items_seen),
		.reads_checked (reads_checked),
		.writes_seen   (writes_seen)
	);

	function automatic logic rbit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [1:0] ab_of(input int pos);
		case (pos)
			0: return 2'b00;
			1: return 2'b01;
			2: return 2'b11;
			default: return 2'b10;
		endcase
	endfunction

	task automatic offer(input logic [CMD_W-1:0] c, input logic a, input logic b,
		input logic lvl);
		in_valid <= 1'b1;
		cmd <= c;
		pin_a <= a;
		pin_b <= b;
		button_level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send(input logic [CMD_W-1:0] c, input logic a, input logic b,
		input logic lvl);
		offer(c, a, b, lvl);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause($urandom_range(1, 8));
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic move_encoder(input int step, input bit gaps);
		logic [1:0] ab;
		ab_pos = (ab_pos + step) % 4;
		ab = ab_of(ab_pos);
		if (gaps)
			send(CMD_ENC, ab[1], ab[0], rbit());
		else
			offer(CMD_ENC, ab[1], ab[0], rbit());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_config(input logic dir, input logic lvl,
		input logic [THRESH_W-1:0] th);
		write_reg(REG_DIR_INVERT, {7'($urandom_range(0, 127)), dir});
		write_reg(REG_BUTTON_LEVEL, {7'($urandom_range(0, 127)), lvl});
		write_reg(REG_STEP_THRESH, th);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(input int fwd_pct, output bit counted);
		int               r;
		int               s;
		int               step;
		logic [CMD_W-1:0] c;
		counted = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			s = $urandom_range(0, 99);
			if (s < 10)
				step = 0;
			else if (s < 18)
				step = 2;
			else if ($urandom_range(0, 99) < fwd_pct)
				step = 1;
			else
				step = 3;
			move_encoder(step, 1'b1);
		end else if (r < 72) begin
			if ($urandom_range(0, 99) < 70)
				btn_drive = ~btn_drive;
			send(CMD_BTN, rbit(), rbit(), btn_drive);
		end else if (r < 94) begin
			case ($urandom_range(0, 2))
				0: c = CMD_TURNS;
				1: c = CMD_STEP;
				default: c = CMD_PRESS;
			endcase
			send(c, rbit(), rbit(), rbit());
		end else begin
			c = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
			send(c, rbit(), rbit(), rbit());
			counted = 1'b0;
		end
	endtask

	// The receiver changes its stall pattern after each random span and
	// holds off completely for a long stretch whenever hold_toggle flips.
	initial begin
		int   mode;
		int   span;
		int   tick;
		logic seen;
		out_ready = 1'b0;
		seen = 1'b0;
		mode = 0;
		span = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_toggle != seen) begin
				seen = hold_toggle;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				span--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= rbit();
					2: out_ready <= (tick % 4 == 0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_quadrature_encoder_with_button_counter: errors");
		$finish;
	end

	initial begin
		int                  phase;
		int                  done;
		int                  fwd_pct;
		int                  k;
		bit                  counted;
		logic                dir;
		logic                lvl;
		logic [THRESH_W-1:0] th;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ENC;
		pin_a = 1'b0;
		pin_b = 1'b0;
		button_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DIR_INVERT;
		cfg_data = '0;
		burst_left = 0;
		btn_drive = 1'b0;
		ab_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: the first sample only records the phases, a step
		// read below the threshold keeps the count, and a jump is ignored.
		send(CMD_ENC, 1'b0, 1'b1, rbit());
		send(CMD_ENC, 1'b1, 1'b1, rbit());
		send(CMD_ENC, 1'b1, 1'b0, rbit());
		send(CMD_ENC, 1'b0, 1'b0, rbit());
		send(CMD_STEP, rbit(), rbit(), rbit());
		send(CMD_ENC, 1'b0, 1'b1, rbit());
		send(CMD_STEP, rbit(), rbit(), rbit());
		send(CMD_ENC, 1'b0, 1'b1, rbit());
		send(CMD_ENC, 1'b1, 1'b0, rbit());
		send(CMD_ENC, 1'b1, 1'b1, rbit());
		send(CMD_ENC, 1'b0, 1'b1, rbit());
		send(CMD_ENC, 1'b0, 1'b0, rbit());
		send(CMD_ENC, 1'b1, 1'b0, rbit());
		send(CMD_ENC, 1'b0, 1'b1, rbit());
		send(CMD_TURNS, rbit(), rbit(), rbit());
		send(CMD_BTN, rbit(), rbit(), 1'b1);
		send(CMD_BTN, rbit(), rbit(), 1'b0);
		send(CMD_BTN, rbit(), rbit(), 1'b0);
		send(CMD_BTN, rbit(), rbit(), 1'b1);
		send(CMD_BTN, rbit(), rbit(), 1'b0);
		send(CMD_PRESS, rbit(), rbit(), rbit());
		send(CMD_SPARE_FIRST, rbit(), rbit(), rbit());
		send(CMD_SPARE_FIRST + 3'd1, rbit(), rbit(), rbit());
		send(CMD_SPARE_FIRST + 3'd2, rbit(), rbit(), rbit());
		send(CMD_PRESS, rbit(), rbit(), rbit());
		send(CMD_TURNS, rbit(), rbit(), rbit());
		ab_pos = 1;

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin dir = 1'b1; lvl = 1'b1; th = 8'd1; end
				1: begin dir = 1'b0; lvl = 1'b1; th = 8'd255; end
				2: begin dir = 1'b1; lvl = 1'b0; th = 8'd0; end
				3: begin dir = 1'b0; lvl = 1'b0; th = STEP_THRESHOLD_RST; end
				default: begin
					dir = rbit();
					lvl = rbit();
					th = 8'($urandom_range(0, 255));
				end
			endcase
			set_config(dir, lvl, th);
			fwd_pct = $urandom_range(20, 80);
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				if (phase == 1 && done == 60) begin
					// Reads keep coming while results are held off, so the
					// block fills and stops taking input transfers.
					hold_toggle <= ~hold_toggle;
					for (k = 0; k < 30; k++)
						offer(k % 2 ? CMD_STEP : CMD_TURNS, rbit(), rbit(), rbit());
					done += 30;
				end
				random_item(fwd_pct, counted);
				if (counted)
					done++;
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Covered %0d input transfers and %0d checked reads over %0d register writes,",
			items_seen, reads_checked, writes_seen);
		$display("with directed cases, six register settings and a long result stall.");
		if (errors == 0)
			$display("tb_quadrature_encoder_with_button_counter: clean");
		else
			$display("tb_quadrature_encoder_with_button_counter: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/qed_pkg.sv
hw/rtl/qed_core.sv
hw/rtl/qed_out.sv
hw/rtl/quadrature_encoder_with_button_counter.sv
verif/qed_checker.sv
verif/tb_quadrature_encoder_with_button_counter.sv
